[rtl/core/ktemf_pkg.sv]
// Shared types, constants and coefficient tables for the type K inverse conversion
`timescale 1ns / 1ps

package ktemf_pkg;

  localparam int unsigned EmfW   = 18;
  localparam int unsigned TempW  = 18;
  localparam int unsigned AccW   = 64;
  localparam int unsigned Terms  = 10;
  localparam int unsigned IdxW   = $clog2(Terms);
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulW   = 2 * MulAW;
  localparam int unsigned QaccW  = 128;
  localparam int unsigned DivCycles = 4;
  localparam int unsigned DivCntW   = $clog2(DivCycles);

  // range edges in microvolts
  localparam logic signed [EmfW-1:0] EmfLow  = -18'sd5891;
  localparam logic signed [EmfW-1:0] EmfMid1 = 18'sd20644;
  localparam logic signed [EmfW-1:0] EmfHigh = 18'sd54886;

  // half of each decimal divisor, added before the divide for rounding
  localparam logic [AccW-1:0] HalfE4 = 64'd5000;
  localparam logic [AccW-1:0] HalfE5 = 64'd50000;
  localparam logic [AccW-1:0] HalfE6 = 64'd500000;

  // power of two taken out of 10^n by a plain shift
  localparam int unsigned ExpE4 = 4;
  localparam int unsigned ExpE5 = 5;
  localparam int unsigned ExpE6 = 6;

  // 5^n is left: ceil(2^k / 5^n), exact for any shifted dividend below 2^60
  localparam int unsigned RecipShE4 = 70;
  localparam int unsigned RecipShE5 = 72;
  localparam int unsigned RecipShE6 = 74;
  localparam logic [AccW-1:0] RecipE4 =
    AccW'(((128'd1 << RecipShE4) + 128'd624) / 128'd625);
  localparam logic [AccW-1:0] RecipE5 =
    AccW'(((128'd1 << RecipShE5) + 128'd3124) / 128'd3125);
  localparam logic [AccW-1:0] RecipE6 =
    AccW'(((128'd1 << RecipShE6) + 128'd15624) / 128'd15625);

  typedef enum logic [1:0] {
    RNG_NEG  = 2'd0,
    RNG_LOW  = 2'd1,
    RNG_HIGH = 2'd2
  } rng_e;

  // decimal divisor of one rounding divide
  typedef enum logic [1:0] {
    DIV_E4 = 2'd0,
    DIV_E5 = 2'd1,
    DIV_E6 = 2'd2
  } div_e;

  // scaled coefficient for power idx of the given range
  function automatic logic signed [AccW-1:0] coef_f(rng_e rng, logic [IdxW-1:0] idx);
    logic signed [AccW-1:0] c;
    c = '0;
    case (rng)
      RNG_NEG: begin
        case (idx)
          4'd1:    c = 64'sd251734620;
          4'd2:    c = -64'sd116628780;
          4'd3:    c = -64'sd1083363800;
          4'd4:    c = -64'sd8977354000;
          4'd5:    c = -64'sd37342377000;
          4'd6:    c = -64'sd86632643000;
          4'd7:    c = -64'sd104505980000;
          4'd8:    c = -64'sd51920577000;
          default: c = '0;
        endcase
      end
      RNG_LOW: begin
        case (idx)
          4'd1:    c = 64'sd2508355000;
          4'd2:    c = 64'sd78601060;
          4'd3:    c = -64'sd2503131000;
          4'd4:    c = 64'sd83152700000;
          4'd5:    c = -64'sd122803400000;
          4'd6:    c = 64'sd98040360000;
          4'd7:    c = -64'sd441303000000;
          4'd8:    c = 64'sd105773400000;
          4'd9:    c = -64'sd10527550000;
          default: c = '0;
        endcase
      end
      RNG_HIGH: begin
        case (idx)
          4'd0:    c = -64'sd131805800;
          4'd1:    c = 64'sd4830222000;
          4'd2:    c = -64'sd16460310000;
          4'd3:    c = 64'sd54647310000;
          4'd4:    c = -64'sd9650715000;
          4'd5:    c = 64'sd8802193000;
          4'd6:    c = -64'sd3110810000;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // divisor applied when folding the product into power idx
  function automatic div_e fold_div_f(rng_e rng, logic [IdxW-1:0] idx);
    div_e d;
    d = DIV_E4;
    case (rng)
      RNG_LOW: begin
        case (idx)
          4'd0, 4'd3, 4'd6: d = DIV_E5;
          default:          d = DIV_E4;
        endcase
      end
      RNG_HIGH: begin
        case (idx)
          4'd3, 4'd7: d = DIV_E4;
          default:    d = DIV_E5;
        endcase
      end
      default: d = DIV_E4;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/ktemf_if.sv]
// Valid/ready channel interfaces for EMF samples and temperature results
`timescale 1ns / 1ps

interface ktemf_in_if
  import ktemf_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [EmfW-1:0] emf_uv;

  modport source (output valid, output emf_uv, input ready);
  modport sink   (input valid, input emf_uv, output ready);
endinterface

interface ktemf_out_if
  import ktemf_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_q6;
  logic                    out_of_range;

  modport source (output valid, output temp_q6, output out_of_range, input ready);
  modport sink   (input valid, input temp_q6, input out_of_range, output ready);
endinterface

[rtl/core/ktype_temperature_from_emf.sv]
// Type K thermocouple EMF to temperature converter, top level
//
// Usage:
//   in_i  carries one signed EMF sample in microvolts (emf_uv). A sample is
//         taken on a transfer (valid and ready high at a rising edge); ready
//         is high only while the sequencer is idle.
//   out_o carries temp_q6 in 1/64 degC and an out_of_range flag, one result
//         per sample, held in an output register until the receiver takes it.
// Sequencing: an in-range sample runs nine Horner folds (two partial products
//   on the shared 33x33 multiplier, a magnitude and rounding-offset step,
//   four partial products of the reciprocal multiply that divides by the
//   decimal scale, one sign and coefficient add), then a final scale to
//   1/64 degC and a step that loads the output register.
//   An out-of-range sample skips the folds and goes straight to the output load.
// A new sample is taken only once the sequencer has finished the previous
//   one and is back in idle.
// A new sample is taken while the previous result still waits on out_o; if
//   the receiver stalls, the next result waits in the sequencer until the
//   output register frees up.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//   out_o.valid.
`timescale 1ns / 1ps

module ktype_temperature_from_emf
  import ktemf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ktemf_in_if.sink          in_i,
  ktemf_out_if.source       out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_WRITE
  } state_e;

  state_e                  state_q;
  logic [IdxW-1:0]         idx_q;
  logic [DivCntW-1:0]      dcnt_q;
  logic                    fin_q;
  logic                    out_valid_q;
  rng_e                    rng_q;

  logic signed [EmfW-1:0]  emf_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  prod_q;
  logic [AccW-1:0]         dvd_q;
  logic [QaccW-1:0]        qacc_q;
  div_e                    dsel_q;
  logic                    neg_q;
  logic signed [TempW-1:0] res_temp_q;
  logic                    res_oor_q;
  logic signed [TempW-1:0] out_temp_q;
  logic                    out_oor_q;

  logic                    in_xfer;
  logic                    out_xfer;
  logic                    in_neg;
  logic                    in_low;
  logic                    in_high;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulAW-1:0] mul_b;
  logic signed [MulW-1:0]  mul_res;
  div_e                    dsel;
  logic signed [AccW-1:0]  prep_src;
  logic [AccW-1:0]         prep_mag;
  logic [AccW-1:0]         prep_sum;
  logic [AccW-1:0]         prep_n;
  logic [AccW-1:0]         recip;
  logic [QaccW-1:0]        pp_ext;
  logic [QaccW-1:0]        pp_sh;
  logic [AccW-1:0]         quot_mag;
  logic signed [AccW-1:0]  quot_s;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.temp_q6      = out_temp_q;
  assign out_o.out_of_range = out_oor_q;

  // range classification of the incoming sample
  assign in_neg  = (in_i.emf_uv >= EmfLow) && (in_i.emf_uv <= 18'sd0);
  assign in_low  = (in_i.emf_uv > 18'sd0) && (in_i.emf_uv <= EmfMid1);
  assign in_high = (in_i.emf_uv > EmfMid1) && (in_i.emf_uv <= EmfHigh);

  // shared multiplier: accumulator words times emf, or dividend times reciprocal
  always_comb begin
    mul_a = {acc_q[AccW-1], acc_q[AccW-1:32]};
    mul_b = {{(MulAW - EmfW){emf_q[EmfW-1]}}, emf_q};
    case (state_q)
      ST_MUL_LO: mul_a = {1'b0, acc_q[31:0]};
      ST_DIV: begin
        mul_a = {1'b0, (dcnt_q[1] ? dvd_q[AccW-1:32] : dvd_q[31:0])};
        mul_b = {1'b0, (dcnt_q[0] ? recip[AccW-1:32] : recip[31:0])};
      end
      default: ;
    endcase
    mul_res = mul_a * mul_b;
  end

  // operand, rounding offset and power-of-two part of the decimal divide
  always_comb begin
    dsel     = fin_q ? DIV_E6 : fold_div_f(rng_q, idx_q);
    prep_src = fin_q ? {acc_q[AccW-7:0], 6'd0} : prod_q;
    prep_mag = prep_src[AccW-1] ? (~prep_src + 64'd1) : prep_src;
    case (dsel)
      DIV_E4: begin
        prep_sum = prep_mag + HalfE4;
        prep_n   = prep_sum >> ExpE4;
      end
      DIV_E5: begin
        prep_sum = prep_mag + HalfE5;
        prep_n   = prep_sum >> ExpE5;
      end
      default: begin
        prep_sum = prep_mag + HalfE6;
        prep_n   = prep_sum >> ExpE6;
      end
    endcase
  end

  // partial product placed at its weight in the reciprocal product
  always_comb begin
    pp_ext = {{(QaccW - AccW){1'b0}}, mul_res[AccW-1:0]};
    if (dcnt_q == '0) begin
      pp_sh = pp_ext;
    end else if (dcnt_q == DivCntW'(DivCycles - 1)) begin
      pp_sh = pp_ext << 64;
    end else begin
      pp_sh = pp_ext << 32;
    end
  end

  // reciprocal of the odd part and signed quotient after the divide
  always_comb begin
    case (dsel_q)
      DIV_E4: begin
        recip    = RecipE4;
        quot_mag = AccW'(qacc_q >> RecipShE4);
      end
      DIV_E5: begin
        recip    = RecipE5;
        quot_mag = AccW'(qacc_q >> RecipShE5);
      end
      default: begin
        recip    = RecipE6;
        quot_mag = AccW'(qacc_q >> RecipShE6);
      end
    endcase
    quot_s = neg_q ? signed'(~quot_mag + 64'd1) : signed'(quot_mag);
  end

  // sequencer and registered output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      dcnt_q      <= '0;
      fin_q       <= 1'b0;
      rng_q       <= RNG_NEG;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_WRITE) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            fin_q <= 1'b0;
            idx_q <= IdxW'(Terms - 2);
            if (in_neg) begin
              rng_q   <= RNG_NEG;
              state_q <= ST_MUL_LO;
            end else if (in_low) begin
              rng_q   <= RNG_LOW;
              state_q <= ST_MUL_LO;
            end else if (in_high) begin
              rng_q   <= RNG_HIGH;
              state_q <= ST_MUL_LO;
            end else begin
              state_q <= ST_WRITE;
            end
          end
        end
        ST_MUL_LO: state_q <= ST_MUL_HI;
        ST_MUL_HI: state_q <= ST_PREP;
        ST_PREP: begin
          dcnt_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DivCntW'(DivCycles - 1)) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (fin_q) begin
            state_q <= ST_WRITE;
          end else if (idx_q == '0) begin
            fin_q   <= 1'b1;
            state_q <= ST_PREP;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= ST_MUL_LO;
          end
        end
        ST_WRITE: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          emf_q      <= in_i.emf_uv;
          res_temp_q <= '0;
          res_oor_q  <= !(in_neg || in_low || in_high);
          if (in_neg) begin
            acc_q <= coef_f(RNG_NEG, IdxW'(Terms - 1));
          end else if (in_low) begin
            acc_q <= coef_f(RNG_LOW, IdxW'(Terms - 1));
          end else begin
            acc_q <= coef_f(RNG_HIGH, IdxW'(Terms - 1));
          end
        end
      end
      ST_MUL_LO: prod_q <= mul_res[AccW-1:0];
      ST_MUL_HI: prod_q <= prod_q + {mul_res[31:0], 32'd0};
      ST_PREP: begin
        neg_q  <= prep_src[AccW-1];
        dvd_q  <= prep_n;
        dsel_q <= dsel;
        qacc_q <= '0;
      end
      ST_DIV: qacc_q <= qacc_q + pp_sh;
      ST_FIX: begin
        if (fin_q) begin
          res_temp_q <= quot_s[TempW-1:0];
        end else begin
          acc_q <= quot_s + coef_f(rng_q, idx_q);
        end
      end
      ST_WRITE: begin
        if (!out_valid_q || out_o.ready) begin
          out_temp_q <= res_temp_q;
          out_oor_q  <= res_oor_q;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/ktemf_chk.sv]
// Port-level assertions for the type K converter, bound to the top level
`timescale 1ns / 1ps

module ktemf_chk
  import ktemf_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [TempW-1:0] temp_q6_i,
  input logic                    out_of_range_i
);

  // out-of-range results carry a zero temperature
  oor_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i |-> temp_q6_i == '0)
    else $error("out_of_range result with nonzero temperature");

  // in-range results stay within the type K span
  temp_span_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_of_range_i |->
      (temp_q6_i >= -18'sd19200) && (temp_q6_i <= 18'sd89600))
    else $error("temperature outside type K span");

  // the sequencer is busy right after taking a sample
  busy_after_take_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high the cycle after a sample transfer");

  // a stalled result holds
  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(temp_q6_i) && $stable(out_of_range_i))
    else $error("result changed while stalled");

endmodule

bind ktype_temperature_from_emf ktemf_chk u_ktemf_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .temp_q6_i      (out_o.temp_q6),
  .out_of_range_i (out_o.out_of_range)
);
